// ----- src/sfcp_pkg.sv -----
// Shared types and constants for the SPI flash command planner.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfcp_pkg;

   localparam int PAGE_BYTES_DEFAULT   = 256;
   localparam int ADDRESS_BITS_DEFAULT = 24;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_ERASE = 2'd1,
      FUNC_NEXT  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_WRITE = 3'b010,
      MODE_ERASE = 3'b100
   } mode_type;

   localparam logic [1:0] REG_ERASE_SMALL  = 2'd0;
   localparam logic [1:0] REG_ERASE_MEDIUM = 2'd1;
   localparam logic [1:0] REG_ERASE_LARGE  = 2'd2;

   localparam logic [7:0] OP_PROGRAM          = 8'h02;
   localparam logic [7:0] ERASE_SMALL_RESET   = 8'd32;
   localparam logic [7:0] ERASE_MEDIUM_RESET  = 8'd82;
   localparam logic [7:0] ERASE_LARGE_RESET   = 8'd216;

   localparam logic [16:0] SIZE_SMALL  = 17'd4096;
   localparam logic [16:0] SIZE_MEDIUM = 17'd32768;
   localparam logic [16:0] SIZE_LARGE  = 17'd65536;

   localparam logic [24:0] BLOCKS_SMALL  = 25'd1;
   localparam logic [24:0] BLOCKS_MEDIUM = 25'd8;
   localparam logic [24:0] BLOCKS_LARGE  = 25'd16;

   typedef struct packed {
      logic [7:0] op_small;
      logic [7:0] op_medium;
      logic [7:0] op_large;
   } erase_cfg_type;

   typedef struct packed {
      logic        valid_res;
      logic [7:0]  opcode;
      logic [24:0] cmd_address;
      logic [16:0] chunk_bytes;
      logic [23:0] payload_offset;
      logic        device;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

// ----- src/sfcp_csr.sv -----
// APB-style register file holding the three erase opcodes.
// Depends on sfcp_pkg for register indexes and reset values.
`default_nettype none

module sfcp_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output sfcp_pkg::erase_cfg_type    cfg
);
   import sfcp_pkg::*;

   logic [7:0] op_small_ff, op_small_in;
   logic [7:0] op_medium_ff, op_medium_in;
   logic [7:0] op_large_ff, op_large_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      op_small_in  = op_small_ff;
      op_medium_in = op_medium_ff;
      op_large_in  = op_large_ff;
      if (wr_en) begin
         case (reg_index)
            REG_ERASE_SMALL:  op_small_in  = csr_pwdata[7:0];
            REG_ERASE_MEDIUM: op_medium_in = csr_pwdata[7:0];
            REG_ERASE_LARGE:  op_large_in  = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ERASE_SMALL:  csr_prdata = {24'd0, op_small_ff};
         REG_ERASE_MEDIUM: csr_prdata = {24'd0, op_medium_ff};
         REG_ERASE_LARGE:  csr_prdata = {24'd0, op_large_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_small_ff  <= ERASE_SMALL_RESET;
         op_medium_ff <= ERASE_MEDIUM_RESET;
         op_large_ff  <= ERASE_LARGE_RESET;
      end else begin
         op_small_ff  <= op_small_in;
         op_medium_ff <= op_medium_in;
         op_large_ff  <= op_large_in;
      end
   end

   assign cfg.op_small  = op_small_ff;
   assign cfg.op_medium = op_medium_ff;
   assign cfg.op_large  = op_large_ff;

endmodule

`default_nettype wire

// ----- src/sfcp_planner.sv -----
// Plan state and next-command logic: at most one command per accepted transaction.
// Depends on sfcp_pkg; page size must be a power of two.
`default_nettype none

module sfcp_planner #(
   parameter int PAGE_BYTES   = sfcp_pkg::PAGE_BYTES_DEFAULT,
   parameter int ADDRESS_BITS = sfcp_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            func,
   input  wire logic [23:0]           start_address,
   input  wire logic [24:0]           length,
   input  wire logic                  target_device,
   input  wire sfcp_pkg::erase_cfg_type cfg,
   output sfcp_pkg::result_type       result
);
   import sfcp_pkg::*;

   localparam int PB = $clog2(PAGE_BYTES);
   localparam int PW = PB + 1;
   localparam logic [23:0] ADDR_MASK = 24'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [PW-1:0] PAGE_SPAN = PW'(PAGE_BYTES);

   mode_type    mode_ff, mode_in;
   logic [24:0] addr_ff, addr_in;
   logic [24:0] remain_ff, remain_in;
   logic [23:0] offset_ff, offset_in;
   logic        cs_ff, cs_in;

   func_type    func_t;
   mode_type    cur_mode;
   logic [24:0] cur_addr;
   logic [24:0] cur_remain;
   logic [23:0] cur_offset;
   logic        cur_cs;

   logic [24:0] start_addr;
   logic [25:0] last_byte;
   logic [13:0] erase_blocks;
   logic [PW-1:0] room;
   logic [16:0] chunk;
   logic [24:0] blocks;
   logic [7:0]  op;
   logic        emit;

   assign func_t       = func_type'(func);
   assign start_addr   = {1'b0, start_address & ADDR_MASK};
   assign last_byte    = {1'b0, start_addr} + {1'b0, length} - 26'd1;
   assign erase_blocks = last_byte[25:12] - {2'b0, start_addr[23:12]} + 14'd1;
   assign room         = PAGE_SPAN - {1'b0, cur_addr[PB-1:0]};

   always_comb begin
      cur_mode   = mode_ff;
      cur_addr   = addr_ff;
      cur_remain = remain_ff;
      cur_offset = offset_ff;
      cur_cs     = cs_ff;
      unique case (func_t)
         FUNC_WRITE, FUNC_ERASE: begin
            cur_addr   = start_addr;
            cur_offset = 24'd0;
            cur_cs     = target_device;
            if (length == 25'd0) begin
               cur_mode   = MODE_IDLE;
               cur_remain = 25'd0;
            end else if (func_t == FUNC_WRITE) begin
               cur_mode   = MODE_WRITE;
               cur_remain = length;
            end else begin
               cur_mode   = MODE_ERASE;
               cur_remain = {11'd0, erase_blocks};
            end
         end
         FUNC_NEXT, FUNC_NONE: ;
      endcase
   end

   // idle mode always goes with nothing remaining, so the mode and func alone gate emission
   assign emit = (func_t != FUNC_NONE) && (cur_mode != MODE_IDLE);

   always_comb begin
      chunk  = 17'd0;
      blocks = 25'd0;
      op     = OP_PROGRAM;
      if (cur_mode == MODE_WRITE) begin
         chunk  = (25'(room) >= cur_remain) ? cur_remain[16:0] : 17'(room);
         blocks = 25'(chunk);
      end else begin
         priority if (cur_remain >= BLOCKS_LARGE) begin
            op = cfg.op_large;  chunk = SIZE_LARGE;  blocks = BLOCKS_LARGE;
         end else if (cur_remain >= BLOCKS_MEDIUM) begin
            op = cfg.op_medium; chunk = SIZE_MEDIUM; blocks = BLOCKS_MEDIUM;
         end else begin
            op = cfg.op_small;  chunk = SIZE_SMALL;  blocks = BLOCKS_SMALL;
         end
      end
   end

   always_comb begin
      mode_in   = cur_mode;
      addr_in   = cur_addr;
      remain_in = cur_remain;
      offset_in = cur_offset;
      cs_in     = cur_cs;
      result    = '0;
      if (emit) begin
         remain_in = cur_remain - blocks;
         addr_in   = cur_addr + 25'(chunk);
         if (cur_mode == MODE_WRITE) begin
            offset_in = cur_offset + 24'(chunk);
         end
         if (remain_in == 25'd0) begin
            mode_in = MODE_IDLE;
         end
         result.valid_res      = 1'b1;
         result.opcode         = op;
         result.cmd_address    = cur_addr;
         result.chunk_bytes    = chunk;
         result.payload_offset = (cur_mode == MODE_WRITE) ? cur_offset : 24'd0;
         result.device         = cur_cs;
         result.last           = (remain_in == 25'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         addr_ff   <= 25'd0;
         remain_ff <= 25'd0;
         offset_ff <= 24'd0;
         cs_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         addr_ff   <= addr_in;
         remain_ff <= remain_in;
         offset_ff <= offset_in;
         cs_ff     <= cs_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/spi_flash_command_planner_top.sv -----
// Top level of the SPI flash command planner: register file, planner, result register.
// Depends on sfcp_pkg, sfcp_csr and sfcp_planner.
`default_nettype none

// Every request transaction yields exactly one response transaction, the next cycle:
// the planner updates its plan state and forms the command in the same cycle the
// request is taken, and the command lands in a single result register. A new request
// is taken every cycle unless a response is waiting and the consumer stalls.
// Start requests (write or erase) open a plan and return its first command; next
// requests return the following commands, with valid_res 0 once no plan is pending.
// Erase opcodes must be programmed via the register port while idle; it is unchecked.
module spi_flash_command_planner_top #(
   parameter int PAGE_BYTES   = sfcp_pkg::PAGE_BYTES_DEFAULT,
   parameter int ADDRESS_BITS = sfcp_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [23:0] req_start_address,
   input  wire logic [24:0] req_length,
   input  wire logic        req_target_device,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_valid_res,
   output logic [7:0]       rsp_opcode,
   output logic [24:0]      rsp_cmd_address,
   output logic [16:0]      rsp_chunk_bytes,
   output logic [23:0]      rsp_payload_offset,
   output logic             rsp_device,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sfcp_pkg::*;

   erase_cfg_type cfg;
   result_type    result;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   sfcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfcp_planner #(
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_planner (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .func          (req_func),
      .start_address (req_start_address),
      .length        (req_length),
      .target_device (req_target_device),
      .cfg           (cfg),
      .result        (result)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   assign rsp_in       = accept ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = rsp_ff.valid_res;
   assign rsp_opcode         = rsp_ff.opcode;
   assign rsp_cmd_address    = rsp_ff.cmd_address;
   assign rsp_chunk_bytes    = rsp_ff.chunk_bytes;
   assign rsp_payload_offset = rsp_ff.payload_offset;
   assign rsp_device         = rsp_ff.device;
   assign rsp_last           = rsp_ff.last;

`ifndef ASSERT_OFF
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_empty_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_opcode == 8'd0 && rsp_cmd_address == 25'd0
         && rsp_chunk_bytes == 17'd0 && rsp_payload_offset == 24'd0
         && !rsp_device && !rsp_last))
      else $error("empty response carries nonzero fields");

   a_cmd_has_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_chunk_bytes != 17'd0))
      else $error("command with zero size");
`endif

endmodule

`default_nettype wire
